// ===== hdl/plob_pkg.sv =====
// shared types and codes for the price level order book
package plob_pkg;

    localparam int unsigned SeqBits = 32;

    typedef enum logic [1:0] {
        MODE_UPDATE = 2'd0,
        MODE_TOP    = 2'd1,
        MODE_DEPTH  = 2'd2,
        MODE_UNUSED = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_TOP    = 2'd0,
        KIND_REJECT = 2'd1,
        KIND_BID    = 2'd2,
        KIND_ASK    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        CMD_NONE   = 3'd0,
        CMD_ERASE  = 3'd1,
        CMD_WRITE  = 3'd2,
        CMD_INSERT = 3'd3,
        CMD_SHIFT  = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] level_price;
        logic [31:0] level_qty;
        logic [15:0] level_orders;
        logic [31:0] bid_price;
        logic [31:0] bid_qty;
        logic [31:0] ask_price;
        logic [31:0] ask_qty;
        logic        bid_present;
        logic        ask_present;
        logic [31:0] sequence_res;
        logic        last;
    } t_out_item;

endpackage

// ===== hdl/plob_if.sv =====
// valid/ready channel interfaces for requests and results
interface plob_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic        side;
    logic [31:0] price;
    logic [31:0] quantity;
    logic [15:0] orders;
    logic [5:0]  depth;
    modport source (output valid, mode, side, price, quantity, orders, depth, input ready);
    modport sink (input valid, mode, side, price, quantity, orders, depth, output ready);
endinterface

interface plob_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] level_price;
    logic [31:0] level_qty;
    logic [15:0] level_orders;
    logic [31:0] bid_price;
    logic [31:0] bid_qty;
    logic [31:0] ask_price;
    logic [31:0] ask_qty;
    logic        bid_present;
    logic        ask_present;
    logic [31:0] sequence_res;
    logic        last;
    modport source (output valid, kind, level_price, level_qty, level_orders, bid_price,
                    bid_qty, ask_price, ask_qty, bid_present, ask_present, sequence_res,
                    last, input ready);
    modport sink (input valid, kind, level_price, level_qty, level_orders, bid_price,
                  bid_qty, ask_price, ask_qty, bid_present, ask_present, sequence_res,
                  last, output ready);
endinterface

// ===== hdl/price_level_order_book_unit.sv =====
// price level order book: two sorted level chains, request and result channels
// update: applied the cycle after acceptance, result loaded in ST_OUT, then back to ST_IDLE
// L1 snapshot (and L2 on an empty book): result valid the cycle after acceptance, stays in ST_IDLE
// L2 snapshot: 2*LEVELS_PER_SIDE shift steps, bids then asks, each chain rotating a full turn
// so the book is restored; steps advance only while the result register is free
// synchronous active-low reset empties both sides and clears the sequence number
module price_level_order_book_unit #(
    parameter int unsigned LEVELS_PER_SIDE = 32,
    parameter int unsigned PRICE_BITS      = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    plob_in_if.sink    i_req,
    plob_out_if.source o_res
);
    import plob_pkg::*;

    localparam int unsigned CntBits  = $clog2(LEVELS_PER_SIDE + 1);
    localparam int unsigned StepBits = $clog2(2 * LEVELS_PER_SIDE);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_APPLY = 4'b0010,
        ST_SNAP  = 4'b0100,
        ST_OUT   = 4'b1000
    } t_state;

    t_state r_state;
    logic   r_ovalid;
    t_out_item r_out, n_out;
    t_out_item r_top, w_top;
    logic [SeqBits-1:0] r_seq;
    logic r_side;
    logic [PRICE_BITS-1:0] r_price;
    logic [31:0] r_qty;
    logic [15:0] r_ord;
    logic [CntBits-1:0] r_nb, r_na;
    logic [StepBits-1:0] r_step;
    logic r_rej;

    logic [CntBits-1:0] w_bcnt, w_acnt;
    logic w_bfound, w_afound;
    logic [PRICE_BITS-1:0] w_bp, w_ap;
    logic [31:0] w_bq, w_aq;
    logic [15:0] w_bo, w_ao;
    t_cmd w_bcmd, w_acmd;
    logic w_shift, w_accept, w_out_free, w_emit;
    logic w_bid_turn, w_bid_emit, w_ask_emit;
    logic [StepBits-1:0] w_ask_idx;
    logic [CntBits-1:0] w_depth;
    logic [5:0] w_dreq;

    assign w_out_free = !r_ovalid || o_res.ready;
    assign i_req.ready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept = i_req.valid && i_req.ready;

    // snapshot step: bid turn first, then ask turn
    assign w_bid_turn = r_step < StepBits'(LEVELS_PER_SIDE);
    assign w_ask_idx  = r_step - StepBits'(LEVELS_PER_SIDE);
    assign w_bid_emit = w_bid_turn && (r_step < StepBits'(r_nb));
    assign w_ask_emit = !w_bid_turn && (w_ask_idx < StepBits'(r_na));

    // chain commands
    assign w_bcmd  = (r_state == ST_APPLY && !r_side) ? CMD_WRITE : CMD_NONE;
    assign w_acmd  = (r_state == ST_APPLY &&  r_side) ? CMD_WRITE : CMD_NONE;
    assign w_shift = (r_state == ST_SNAP) && w_out_free;

    plob_side #(.Levels(LEVELS_PER_SIDE), .PriceBits(PRICE_BITS), .IsAsk(1'b0)) u_bid (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_bcmd),
        .i_shift(w_shift && w_bid_turn),
        .i_price(r_price), .i_qty(r_qty), .i_orders(r_ord),
        .o_count(w_bcnt), .o_found(w_bfound),
        .o_head_price(w_bp), .o_head_qty(w_bq), .o_head_orders(w_bo)
    );

    plob_side #(.Levels(LEVELS_PER_SIDE), .PriceBits(PRICE_BITS), .IsAsk(1'b1)) u_ask (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_acmd),
        .i_shift(w_shift && !w_bid_turn),
        .i_price(r_price), .i_qty(r_qty), .i_orders(r_ord),
        .o_count(w_acnt), .o_found(w_afound),
        .o_head_price(w_ap), .o_head_qty(w_aq), .o_head_orders(w_ao)
    );

    // clamp snapshot depth
    always_comb begin
        w_dreq = (i_req.depth == '0) ? 6'd1 : i_req.depth;
        if ({26'd0, w_dreq} > 32'(LEVELS_PER_SIDE)) begin
            w_depth = CntBits'(LEVELS_PER_SIDE);
        end else begin
            w_depth = CntBits'(w_dreq);
        end
    end

    // top of book fields from the chain heads
    always_comb begin
        w_top              = '0;
        w_top.bid_present  = w_bcnt != '0;
        w_top.ask_present  = w_acnt != '0;
        w_top.bid_price    = w_top.bid_present ? 32'(w_bp) : '0;
        w_top.bid_qty      = w_top.bid_present ? w_bq : '0;
        w_top.ask_price    = w_top.ask_present ? 32'(w_ap) : '0;
        w_top.ask_qty      = w_top.ask_present ? w_aq : '0;
        w_top.sequence_res = r_seq;
    end

    logic w_rej_now;
    assign w_rej_now = (r_qty != '0) && !(r_side ? w_afound : w_bfound) &&
                       ((r_side ? w_acnt : w_bcnt) >= CntBits'(LEVELS_PER_SIDE));

    // next result and when it is loaded
    always_comb begin
        w_emit     = 1'b0;
        n_out      = w_top;
        n_out.kind = KIND_TOP;
        n_out.last = 1'b1;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (t_mode'(i_req.mode) == MODE_TOP ||
                    (t_mode'(i_req.mode) == MODE_DEPTH && w_bcnt == '0 && w_acnt == '0))) begin
                    w_emit = 1'b1;
                end
            end
            ST_OUT: begin
                w_emit             = w_out_free;
                n_out.kind         = r_rej ? KIND_REJECT : KIND_TOP;
                n_out.level_price  = 32'(r_price);
                n_out.level_qty    = r_qty;
                n_out.level_orders = r_ord;
            end
            ST_SNAP: begin
                // top of book held from acceptance while the chains rotate
                w_emit = w_out_free && (w_bid_emit || w_ask_emit);
                n_out  = r_top;
                if (w_bid_turn) begin
                    n_out.kind         = KIND_BID;
                    n_out.level_price  = 32'(w_bp);
                    n_out.level_qty    = w_bq;
                    n_out.level_orders = w_bo;
                    n_out.last = (r_na == '0) && (r_step + 1'b1 == StepBits'(r_nb));
                end else begin
                    n_out.kind         = KIND_ASK;
                    n_out.level_price  = 32'(w_ap);
                    n_out.level_qty    = w_aq;
                    n_out.level_orders = w_ao;
                    n_out.last = (w_ask_idx + 1'b1 == StepBits'(r_na));
                end
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_seq    <= '0;
        end else begin
            if (w_emit) begin
                r_ovalid <= 1'b1;
                r_out    <= n_out;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_side  <= i_req.side;
                        r_price <= PRICE_BITS'(i_req.price);
                        r_qty   <= i_req.quantity;
                        r_ord   <= i_req.orders;
                        r_step  <= '0;
                        r_top   <= w_top;
                        r_nb    <= (w_bcnt < w_depth) ? w_bcnt : w_depth;
                        r_na    <= (w_acnt < w_depth) ? w_acnt : w_depth;
                        case (t_mode'(i_req.mode))
                            MODE_UPDATE: r_state <= ST_APPLY;
                            MODE_DEPTH: begin
                                if (w_bcnt != '0 || w_acnt != '0) begin
                                    r_state <= ST_SNAP;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_APPLY: begin
                    r_rej <= w_rej_now;
                    if (!w_rej_now) r_seq <= r_seq + 1'b1;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_SNAP: begin
                    if (w_out_free) begin
                        if (r_step == StepBits'(2 * LEVELS_PER_SIDE - 1)) begin
                            r_state <= ST_IDLE;
                        end
                        r_step <= r_step + 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_res.valid        = r_ovalid;
    assign o_res.kind         = r_out.kind;
    assign o_res.level_price  = r_out.level_price;
    assign o_res.level_qty    = r_out.level_qty;
    assign o_res.level_orders = r_out.level_orders;
    assign o_res.bid_price    = r_out.bid_price;
    assign o_res.bid_qty      = r_out.bid_qty;
    assign o_res.ask_price    = r_out.ask_price;
    assign o_res.ask_qty      = r_out.ask_qty;
    assign o_res.bid_present  = r_out.bid_present;
    assign o_res.ask_present  = r_out.ask_present;
    assign o_res.sequence_res = r_out.sequence_res;
    assign o_res.last         = r_out.last;
endmodule

// ===== hdl/plob_cell.sv =====
// one level slot of a sorted side: holds price, quantity and order count
module plob_cell #(
    parameter int unsigned PriceBits = 32
) (
    input  logic                 i_clk,
    input  logic                 i_op_match,   // update hits this price
    input  logic                 i_op_ahead,   // new price ranks ahead of this slot
    input  logic                 i_prev_ahead, // new price ranks ahead of the left slot
    input  logic                 i_prev_valid, // left neighbor exists in the chain
    input  plob_pkg::t_cmd       i_cmd,
    input  logic                 i_del_left,   // a slot left of or at this one was erased
    input  logic [PriceBits-1:0] i_new_price,
    input  logic [31:0]          i_new_qty,
    input  logic [15:0]          i_new_orders,
    input  logic [PriceBits-1:0] i_left_price,
    input  logic [31:0]          i_left_qty,
    input  logic [15:0]          i_left_orders,
    input  logic [PriceBits-1:0] i_right_price,
    input  logic [31:0]          i_right_qty,
    input  logic [15:0]          i_right_orders,
    output logic [PriceBits-1:0] o_price,
    output logic [31:0]          o_qty,
    output logic [15:0]          o_orders
);
    import plob_pkg::*;

    logic [PriceBits-1:0] r_price, n_price;
    logic [31:0]          r_qty, n_qty;
    logic [15:0]          r_orders, n_orders;

    // next slot contents for each chain operation
    always_comb begin
        n_price  = r_price;
        n_qty    = r_qty;
        n_orders = r_orders;
        case (i_cmd)
            CMD_WRITE: begin
                if (i_op_match) begin
                    n_qty    = i_new_qty;
                    n_orders = i_new_orders;
                end
            end
            CMD_ERASE: begin
                if (i_del_left) begin
                    n_price  = i_right_price;
                    n_qty    = i_right_qty;
                    n_orders = i_right_orders;
                end
            end
            CMD_INSERT: begin
                if (i_op_ahead) begin
                    if (i_prev_valid && i_prev_ahead) begin
                        n_price  = i_left_price;
                        n_qty    = i_left_qty;
                        n_orders = i_left_orders;
                    end else begin
                        n_price  = i_new_price;
                        n_qty    = i_new_qty;
                        n_orders = i_new_orders;
                    end
                end
            end
            CMD_SHIFT: begin
                n_price  = i_right_price;
                n_qty    = i_right_qty;
                n_orders = i_right_orders;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_price  <= n_price;
        r_qty    <= n_qty;
        r_orders <= n_orders;
    end

    assign o_price  = r_price;
    assign o_qty    = r_qty;
    assign o_orders = r_orders;
endmodule

// ===== hdl/plob_side.sv =====
// one book side: a chain of level cells plus its fill count
module plob_side #(
    parameter int unsigned Levels    = 32,
    parameter int unsigned PriceBits = 32,
    parameter bit          IsAsk     = 1'b0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  plob_pkg::t_cmd         i_cmd,      // CMD_NONE or an update; resolved here
    input  logic                   i_shift,    // snapshot: rotate toward head
    input  logic [PriceBits-1:0]   i_price,
    input  logic [31:0]            i_qty,
    input  logic [15:0]            i_orders,
    output logic [$clog2(Levels+1)-1:0] o_count,
    output logic                   o_found,
    output logic [PriceBits-1:0]   o_head_price,
    output logic [31:0]            o_head_qty,
    output logic [15:0]            o_head_orders
);
    import plob_pkg::*;

    localparam int unsigned CntBits = $clog2(Levels + 1);

    logic [PriceBits-1:0] w_price  [Levels];
    logic [31:0]          w_qty    [Levels];
    logic [15:0]          w_orders [Levels];
    logic [Levels-1:0]    w_valid, w_match, w_ahead, w_del;
    logic [CntBits-1:0]   r_count, n_count;
    t_cmd                 w_cmd;

    // per-slot compares against the update price
    for (genvar g = 0; g < Levels; g++) begin : g_cmp
        assign w_valid[g] = CntBits'(g) < r_count;
        assign w_match[g] = w_valid[g] && (w_price[g] == i_price);
        assign w_ahead[g] = !w_valid[g] ||
                            (IsAsk ? (i_price < w_price[g]) : (i_price > w_price[g]));
    end

    // erase shifts every slot at or right of the hit
    always_comb begin
        w_del[0] = w_match[0];
        for (int k = 1; k < Levels; k++) begin
            w_del[k] = w_del[k-1] | w_match[k];
        end
    end

    assign o_found = |w_match;

    // resolve a snapshot shift or the requested update into a chain operation
    always_comb begin
        w_cmd   = CMD_NONE;
        n_count = r_count;
        if (i_shift) begin
            w_cmd = CMD_SHIFT;
        end else if (i_cmd != CMD_NONE) begin
            if (i_qty == '0) begin
                if (o_found) begin
                    w_cmd   = CMD_ERASE;
                    n_count = r_count - 1'b1;
                end
            end else if (o_found) begin
                w_cmd = CMD_WRITE;
            end else if (r_count < CntBits'(Levels)) begin
                w_cmd   = CMD_INSERT;
                n_count = r_count + 1'b1;
            end
        end
    end

    for (genvar g = 0; g < Levels; g++) begin : g_cell
        localparam int unsigned L = (g == 0) ? 0 : g - 1;
        localparam int unsigned R = (g == Levels - 1) ? 0 : g + 1;
        plob_cell #(.PriceBits(PriceBits)) u_cell (
            .i_clk          (i_clk),
            .i_op_match     (w_match[g]),
            .i_op_ahead     (w_ahead[g]),
            .i_prev_ahead   (w_ahead[L]),
            .i_prev_valid   (g != 0),
            .i_cmd          (w_cmd),
            .i_del_left     (w_del[g]),
            .i_new_price    (i_price),
            .i_new_qty      (i_qty),
            .i_new_orders   (i_orders),
            .i_left_price   (w_price[L]),
            .i_left_qty     (w_qty[L]),
            .i_left_orders  (w_orders[L]),
            // shift wraps the head around to the tail so the book comes back intact
            .i_right_price  (w_price[(g == Levels - 1) ? 0 : R]),
            .i_right_qty    (w_qty[(g == Levels - 1) ? 0 : R]),
            .i_right_orders (w_orders[(g == Levels - 1) ? 0 : R]),
            .o_price        (w_price[g]),
            .o_qty          (w_qty[g]),
            .o_orders       (w_orders[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count       = r_count;
    assign o_head_price  = w_price[0];
    assign o_head_qty    = w_qty[0];
    assign o_head_orders = w_orders[0];
endmodule
